/* design/svpwm_pkg.sv */
`timescale 1ns / 1ps

package svpwm_pkg;

	// Width of the voltage command fields, signed Q2.(VOLTAGE_WIDTH-2).
	localparam int VOLTAGE_WIDTH = 16;
	localparam int FRAC_BITS     = VOLTAGE_WIDTH - 2;
	// Phase voltages carry 16 extra fraction bits from the sqrt(3)/2 constant.
	localparam int SCALE_SHIFT   = FRAC_BITS + 16;

	// sqrt(3)/2 in unsigned Q0.16, rounded to nearest.
	localparam int K_W           = 17;
	localparam logic [K_W-1:0] K_SQRT3_2 = 17'd56756;

	// Widths of the intermediate values.
	localparam int KBETA_W       = VOLTAGE_WIDTH + K_W;
	localparam int PHASE_W       = VOLTAGE_WIDTH + 18;
	localparam int SUM_W         = PHASE_W + 1;
	localparam int D2_W          = PHASE_W + 3;
	localparam int DUTY_W        = SCALE_SHIFT + 2;
	localparam int PERIOD_W      = 16;
	localparam int COMPARE_W     = 16;
	localparam int PROD_W        = DUTY_W + PERIOD_W;
	localparam int NUM_PHASES    = 3;

	// Configuration port.
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 2;
	localparam logic [APB_ADDR_W-1:0] REG_CARRIER_PERIOD_ADDR = 2'd0;
	localparam logic [PERIOD_W-1:0]   CARRIER_PERIOD_RESET    = 16'd1023;

	typedef logic signed [VOLTAGE_WIDTH-1:0] voltage_t;
	typedef logic signed [PHASE_W-1:0]       phase_t;
	typedef logic        [DUTY_W-1:0]        duty_t;
	typedef logic        [COMPARE_W-1:0]     compare_t;

endpackage

/* design/svpwm_min_max_modulator.sv */
`timescale 1ns / 1ps

// Space-vector PWM modulator with min-max center injection.
// Input channel: a transaction carries voltage_alpha and voltage_beta, signed
// Q2.14 (16384 is 1.0). It is accepted at a rising edge with in_valid high and
// in_stall low. Output channel: a transaction carries compare_a, compare_b and
// compare_c, each between 0 and the carrier period, and completes at a rising
// edge with out_valid high and out_stall low. Every input gives exactly one output.
// The carrier period register is written through the APB port at byte address 0
// and should only be changed while the pipeline is empty; reads return its value.
// The pipeline has five register stages (beta product, inverse Clarke, min-max
// sum, clamped twice duty, period product) and takes one transaction per cycle
// while the receiver does not stall. out_valid rises when the transaction reaches
// the period product stage, and the result can be taken from then on.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline, clears all valid bits, and sets the carrier
// period to 1023.
module svpwm_min_max_modulator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  svpwm_pkg::voltage_t                    voltage_alpha,
	input  svpwm_pkg::voltage_t                    voltage_beta,
	// Output channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output svpwm_pkg::compare_t                    compare_a,
	output svpwm_pkg::compare_t                    compare_b,
	output svpwm_pkg::compare_t                    compare_c,
	// Configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [svpwm_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [svpwm_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [svpwm_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                   pready
);
	import svpwm_pkg::*;

	localparam logic signed [D2_W-1:0] ONE_D2  = D2_W'(64'sd1 <<< SCALE_SHIFT);
	localparam logic signed [D2_W-1:0] FULL_D2 = D2_W'(64'sd1 <<< (SCALE_SHIFT + 1));

	// ------------------------------------------------------------------
	// Configuration register.
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] carrier_period_q;
	logic                cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_period_q <= CARRIER_PERIOD_RESET;
		end else if (cfg_write && (paddr == REG_CARRIER_PERIOD_ADDR)) begin
			carrier_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_CARRIER_PERIOD_ADDR) begin
			prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, carrier_period_q};
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: the stages move together unless a finished result
	// is being held by the receiver.
	// ------------------------------------------------------------------
	logic advance;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign advance  = !(valid_s5 && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the beta product K * beta.
	// ------------------------------------------------------------------
	voltage_t                   alpha_s1;
	logic signed [KBETA_W-1:0]  kbeta_s1;
	logic signed [KBETA_W-1:0]  kbeta_next;

	always_comb begin
		kbeta_next = KBETA_W'(voltage_beta) * $signed({{(KBETA_W-K_W){1'b0}}, K_SQRT3_2});
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			alpha_s1 <= voltage_alpha;
			kbeta_s1 <= kbeta_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: inverse Clarke. a = alpha, b/c = -alpha/2 +/- K*beta,
	// all scaled by 2^16.
	// ------------------------------------------------------------------
	phase_t phase_s2 [NUM_PHASES];
	phase_t va_next, half_next, kb_ext;

	always_comb begin
		va_next   = PHASE_W'(alpha_s1) <<< 16;
		half_next = -(PHASE_W'(alpha_s1) <<< 15);
		kb_ext    = PHASE_W'(kbeta_s1);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2[0] <= va_next;
			phase_s2[1] <= half_next + kb_ext;
			phase_s2[2] <= half_next - kb_ext;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: min + max of the three phases.
	// ------------------------------------------------------------------
	phase_t                   phase_s3 [NUM_PHASES];
	logic signed [SUM_W-1:0]  sum_s3;
	phase_t                   vmin, vmax;

	always_comb begin
		vmin = phase_s2[0];
		vmax = phase_s2[0];
		for (int i = 1; i < NUM_PHASES; i++) begin
			if (phase_s2[i] < vmin) begin
				vmin = phase_s2[i];
			end
			if (phase_s2[i] > vmax) begin
				vmax = phase_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s3 <= phase_s2;
			sum_s3   <= SUM_W'(vmin) + SUM_W'(vmax);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: twice the duty, 2v - (min + max) + 1.0, clamped to [0, 2.0].
	// ------------------------------------------------------------------
	duty_t                   duty_s4 [NUM_PHASES];
	logic signed [D2_W-1:0]  d2 [NUM_PHASES];
	duty_t                   duty_next [NUM_PHASES];

	always_comb begin
		for (int i = 0; i < NUM_PHASES; i++) begin
			d2[i] = (D2_W'(phase_s3[i]) <<< 1) - D2_W'(sum_s3) + ONE_D2;
			if (d2[i] < 0) begin
				duty_next[i] = '0;
			end else if (d2[i] > FULL_D2) begin
				duty_next[i] = FULL_D2[DUTY_W-1:0];
			end else begin
				duty_next[i] = d2[i][DUTY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s4 <= duty_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: scale by the period and truncate.
	// ------------------------------------------------------------------
	compare_t            compare_s5 [NUM_PHASES];
	logic [PROD_W-1:0]   prod [NUM_PHASES];

	always_comb begin
		for (int i = 0; i < NUM_PHASES; i++) begin
			prod[i] = PROD_W'(duty_s4[i]) * PROD_W'(carrier_period_q);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < NUM_PHASES; i++) begin
				compare_s5[i] <= prod[i][SCALE_SHIFT+1 +: COMPARE_W];
			end
		end
	end

	assign out_valid = valid_s5;
	assign compare_a = compare_s5[0];
	assign compare_b = compare_s5[1];
	assign compare_c = compare_s5[2];

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_hold_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && out_stall) |-> in_stall)
		else $error("Input taken while a result is held.");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("Accepted transaction did not enter stage 1.");

	a_compare_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (compare_a <= carrier_period_q && compare_b <= carrier_period_q &&
			compare_c <= carrier_period_q))
		else $error("Compare value exceeds the PWM period.");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (duty_s4[0] <= FULL_D2[DUTY_W-1:0] &&
			duty_s4[1] <= FULL_D2[DUTY_W-1:0] && duty_s4[2] <= FULL_D2[DUTY_W-1:0]))
		else $error("Clamped duty out of range.");

endmodule

/* test/svpwm_min_max_modulator_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the min-max injection SVPWM modulator.
// Every command transaction that the block accepts is turned into three expected
// compare values by a behavioral model of the math below. That model works in
// 64-bit integers and mirrors the fixed-point scaling. Each result transaction is
// checked field by field against the oldest pending expectation.
module svpwm_min_max_modulator_tb;

	import svpwm_pkg::*;

	// sqrt(3)/2 in unsigned Q0.16, the same rounding the datapath is specified with.
	localparam longint SQRT3_OVER_2 = 56756;
	localparam int     RANDOM_PHASES = 6;
	localparam int     ITEMS_PER_PHASE = 117;
	localparam int     LONG_HOLD_CYCLES = 300;
	localparam int     NUM_DIRECTED = 20;

	typedef struct {
		compare_t a;
		compare_t b;
		compare_t c;
	} compare_set_t;

	// One row of the directed table. Where the expected compares are obvious by
	// inspection they are typed in and 'typed' is set; otherwise the model decides.
	typedef struct {
		int period;
		int alpha;
		int beta;
		bit typed;
		int want_a;
		int want_b;
		int want_c;
	} directed_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	voltage_t                   voltage_alpha;
	voltage_t                   voltage_beta;
	logic                       out_valid;
	logic                       out_stall;
	compare_t                   compare_a;
	compare_t                   compare_b;
	compare_t                   compare_c;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [APB_ADDR_W-1:0]      paddr;
	logic [APB_DATA_W-1:0]      pwdata;
	logic [APB_DATA_W-1:0]      prdata;
	logic                       pready;

	// The bench's own copy of the period register, updated at the write edge.
	logic [PERIOD_W-1:0]        active_period = CARRIER_PERIOD_RESET;
	compare_set_t               expected_compares [$];
	int                         mismatch_count = 0;
	bit                         sender_idles = 1'b1;
	bit                         receiver_idles = 1'b1;
	bit                         hold_off_request = 1'b0;

	// Extremes of both axes with their saturated results first, then a few points in
	// the linear region. Then the largest, smallest and zero periods.
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{ 1023,      0,      0, 1,   511,   511,   511},
		'{ 1023,  32767,      0, 1,  1023,     0,     0},
		'{ 1023, -32768,      0, 1,     0,  1023,  1023},
		'{ 1023,      0,  32767, 1,   511,  1023,     0},
		'{ 1023,      0, -32768, 1,   511,     0,  1023},
		'{ 1023,   8192,      0, 0,     0,     0,     0},
		'{ 1023,      0,   8192, 0,     0,     0,     0},
		'{ 1023,  -5000,  12000, 0,     0,     0,     0},
		'{ 1023,  16384, -16384, 0,     0,     0,     0},
		'{ 1023,      1,     -1, 0,     0,     0,     0},
		'{65535,      0,      0, 1, 32767, 32767, 32767},
		'{65535,  32767,  32767, 0,     0,     0,     0},
		'{65535, -32768, -32768, 0,     0,     0,     0},
		'{65535,  32767,      0, 1, 65535,     0,     0},
		'{65535,  12345,  -6789, 0,     0,     0,     0},
		'{    1,      0,      0, 1,     0,     0,     0},
		'{    1,  32767,      0, 1,     1,     0,     0},
		'{    1,     -1,     -1, 0,     0,     0,     0},
		'{    0,  32767,      0, 1,     0,     0,     0},
		'{    0, -32768,  32767, 1,     0,     0,     0}
	};

	svpwm_min_max_modulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.voltage_alpha (voltage_alpha),
		.voltage_beta  (voltage_beta),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.compare_a     (compare_a),
		.compare_b     (compare_b),
		.compare_c     (compare_c),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #10 clk = ~clk;

	// Clamp twice the duty to [0, 2.0] and scale it by the period. Since twice the
	// duty is used, the shift is one more than the phase scaling. Dropping the low
	// bits truncates toward zero because the value is never negative here.
	function automatic compare_t scale_duty(longint twice_duty, logic [PERIOD_W-1:0] period);
		longint full_scale;
		longint clamped;
		full_scale = longint'(1) << (SCALE_SHIFT + 1);
		clamped = twice_duty;
		if (clamped < 0)
			clamped = 0;
		else if (clamped > full_scale)
			clamped = full_scale;
		return compare_t'((clamped * longint'({1'b0, period})) >> (SCALE_SHIFT + 1));
	endfunction

	// Inverse Clarke, then min-max center injection. All phase voltages are kept
	// exact with 16 extra fraction bits, so 1.0 is 2^SCALE_SHIFT. The half of
	// (min + max) is never rounded because twice the duty is formed instead.
	function automatic compare_set_t predict_compares(voltage_t alpha, voltage_t beta,
			logic [PERIOD_W-1:0] period);
		longint al;
		longint be;
		longint unity;
		longint half_alpha;
		longint k_beta;
		longint va;
		longint vb;
		longint vc;
		longint vmin;
		longint vmax;
		longint mid_sum;
		compare_set_t res;
		al = alpha;
		be = beta;
		unity = longint'(1) << SCALE_SHIFT;
		half_alpha = al * -32768;
		k_beta = be * SQRT3_OVER_2;
		va = al * 65536;
		vb = half_alpha + k_beta;
		vc = half_alpha - k_beta;
		vmin = va;
		vmax = va;
		if (vb < vmin) vmin = vb;
		if (vc < vmin) vmin = vc;
		if (vb > vmax) vmax = vb;
		if (vc > vmax) vmax = vc;
		mid_sum = vmin + vmax;
		res.a = scale_duty(2 * va - mid_sum + unity, period);
		res.b = scale_duty(2 * vb - mid_sum + unity, period);
		res.c = scale_duty(2 * vc - mid_sum + unity, period);
		return res;
	endfunction

	// Random commands mix the linear region, the saturated extremes, a few corner
	// codes and raw 16-bit patterns, so that every bit of both fields toggles.
	function automatic voltage_t draw_voltage();
		int magnitude;
		case ($urandom_range(0, 3))
			0: begin
				return voltage_t'($urandom);
			end
			1: begin
				return voltage_t'(int'($urandom_range(0, 18000)) - 9000);
			end
			2: begin
				magnitude = 30000 + int'($urandom_range(0, 2767));
				return $urandom_range(0, 1) ? voltage_t'(magnitude) : voltage_t'(-magnitude - 1);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return voltage_t'(-32768);
					1: return voltage_t'(-1);
					2: return voltage_t'(0);
					3: return voltage_t'(1);
					default: return voltage_t'(32767);
				endcase
			end
		endcase
	endfunction

	task automatic check_compare(string field, compare_t want, compare_t got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Present one command transaction after an optional idle gap and hold it until the
	// block takes it. The expectation is queued at the accepting edge, using the period
	// in force then. in_valid stays high when the next transaction follows right away.
	task automatic offer_command(voltage_t alpha, voltage_t beta, bit typed,
			compare_set_t typed_set);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		voltage_alpha <= alpha;
		voltage_beta <= beta;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_compares.push_back(typed ? typed_set : predict_compares(alpha, beta,
			active_period));
	endtask

	// Stop offering and let every outstanding result come back. The period is only
	// changed while the pipeline is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_compares.size() != 0) @(posedge clk);
	endtask

	// APB write to the period register followed by a read-back. The upper data bits
	// carry noise, which the register must ignore.
	task automatic write_period(logic [PERIOD_W-1:0] value);
		logic [APB_DATA_W-PERIOD_W-1:0] noise;
		noise = (APB_DATA_W-PERIOD_W)'($urandom);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_CARRIER_PERIOD_ADDR;
		pwdata <= {noise, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		active_period = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[PERIOD_W-1:0] !== value) begin
			mismatch_count++;
			$display("%0t ns: carrier period read expected %0d, actual %0d", $time, value,
				prdata[PERIOD_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side. Before each transaction the receiver stalls for a random number of
	// cycles, or not at all in phases without idling. When asked, it holds off once for
	// a long stretch so that the pipeline backs up into the input channel.
	initial begin : result_collector
		int unsigned wait_cycles;
		compare_set_t want;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				wait_cycles = LONG_HOLD_CYCLES;
			end else begin
				wait_cycles = receiver_idles ? $urandom_range(0, 19) : 0;
			end
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_compares.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result a=%0d b=%0d c=%0d with nothing expected", $time,
					compare_a, compare_b, compare_c);
			end else begin
				want = expected_compares.pop_front();
				check_compare("compare_a", want.a, compare_a);
				check_compare("compare_b", want.b, compare_b);
				check_compare("compare_c", want.c, compare_c);
			end
		end
	end

	// Command side and sequencing: reset, the directed table, then random phases that
	// each run under a new period.
	initial begin : command_sequencer
		compare_set_t typed_set;
		compare_set_t unused_set;
		logic [PERIOD_W-1:0] next_period;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		voltage_alpha <= '0;
		voltage_beta <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		unused_set = '{default: '0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// The first rows run under the reset value of the period, so they also
		// confirm that reset loads it.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].period != active_period) begin
				drain_results();
				write_period(PERIOD_W'(directed_rows[i].period));
			end
			typed_set.a = compare_t'(directed_rows[i].want_a);
			typed_set.b = compare_t'(directed_rows[i].want_b);
			typed_set.c = compare_t'(directed_rows[i].want_c);
			offer_command(voltage_t'(directed_rows[i].alpha), voltage_t'(directed_rows[i].beta),
				directed_rows[i].typed, typed_set);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: next_period = 16'hFFFF;
				1: next_period = 16'd1;
				3: next_period = CARRIER_PERIOD_RESET;
				default: next_period = PERIOD_W'($urandom_range(2, 65534));
			endcase
			drain_results();
			write_period(next_period);
			sender_idles = 1'($urandom_range(0, 1));
			receiver_idles = 1'($urandom_range(0, 1));
			// In this phase the sender pushes back to back while the receiver
			// holds off, so the block has to fill up and stall its input.
			if (phase == 2) begin
				sender_idles = 1'b0;
				hold_off_request = 1'b1;
			end
			repeat (ITEMS_PER_PHASE)
				offer_command(draw_voltage(), draw_voltage(), 1'b0, unused_set);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("svpwm_min_max_modulator_tb passed");
		else
			$display("svpwm_min_max_modulator_tb failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run (every transaction waiting out
	// the longest gaps on both sides, the long hold-off and the register writes).
	initial begin : watchdog
		#5000000;
		$display("svpwm_min_max_modulator_tb failed");
		$finish;
	end

endmodule
